>>> design/sdspi_pkg.sv
// Package for the SD SPI host sequencer: word types, op, config index and status codes.
// No dependencies.
package sdspi_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] lba;
    logic [7:0]  rx_byte;
    logic [7:0]  wr_byte;
  } in_word_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cs_n;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        need_wr_byte;
    logic        done_res;
    logic [3:0]  status;
    logic [32:0] capacity_blocks;
    logic        is_sdhc;
    logic        ready_res;
  } out_word_t;

  localparam logic [2:0] OP_INIT = 3'd0, OP_READ = 3'd1, OP_WRITE = 3'd2, OP_CAP = 3'd3,
                         OP_BYTE = 3'd4, OP_TICK = 3'd5;

  localparam logic [2:0] CFG_INIT_TO = 3'd0, CFG_TOKEN_TO = 3'd1, CFG_BUSY_TO = 3'd2,
                         CFG_TRIES = 3'd3, CFG_WAKE = 3'd4;

  localparam logic [3:0] ST_OK = 4'd0, ST_NOT_READY = 4'd1, ST_IDLE_FAIL = 4'd2,
                         ST_IF_COND = 4'd3, ST_INIT_TO = 4'd4, ST_OCR_FAIL = 4'd5,
                         ST_BLKLEN = 4'd6, ST_REJECT = 4'd7, ST_TOKEN_TO = 4'd8,
                         ST_DATA_REJ = 4'd9, ST_BUSY_TO = 4'd10, ST_CAP_FAIL = 4'd11;

  localparam int BlockBytes = 512;
  localparam logic [9:0] BLOCK_CNT = 10'(BlockBytes);
endpackage

>>> design/sd_spi_host_controller.sv
// SD card SPI-mode host sequencer, top level.
// Depends on sdspi_pkg.
//
// channel  direction  handshake        word
// in       input      in_valid/stall   sdspi_pkg::in_word_t
// out      output     out_valid/stall  sdspi_pkg::out_word_t
// cfg      input      cfg_valid/ready  index (3 bit) + data (16 bit)
//
// Each word is handled from the input register; at most one result.
// A new word is taken every cycle while the output register is free or drains.
// in_stall_o rises only when a result is held and out_stall_i is high.
// Reset is asynchronous; no clearing pass. cfg is always ready.
module sd_spi_host_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sdspi_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sdspi_pkg::out_word_t out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [15:0]          cfg_data_i
);
  import sdspi_pkg::*;

  localparam logic [4:0] PH_IDLE = 5'd0, PH_WAKE = 5'd1, PH_CMD0 = 5'd2, PH_CMD8 = 5'd3,
    PH_R7 = 5'd4, PH_CMD55 = 5'd5, PH_CMD41 = 5'd6, PH_CMD58 = 5'd7, PH_OCR = 5'd8,
    PH_CMD16 = 5'd9, PH_INIT_TAIL = 5'd10, PH_CMD17 = 5'd11, PH_RTOKEN = 5'd12,
    PH_RDATA = 5'd13, PH_RCRC = 5'd14, PH_TAIL = 5'd15, PH_CMD24 = 5'd16, PH_WGAP = 5'd17,
    PH_WTOKEN = 5'd18, PH_WDATA = 5'd19, PH_WCRC = 5'd20, PH_WRESP = 5'd21,
    PH_WBUSY = 5'd22, PH_CMD9 = 5'd23, PH_CTOKEN = 5'd24, PH_CSD = 5'd25,
    PH_CCRC = 5'd26, PH_CAP_TAIL = 5'd27;

  logic [15:0] init_to_q, token_to_q, busy_to_q;
  logic [7:0]  tries_q, wake_q;
  logic [4:0]  phase_q, phase_d;
  logic [9:0]  bcnt_q, bcnt_d;
  logic [7:0]  try_q, try_d;
  logic [15:0] ms_q, ms_d;
  logic        blk_q, blk_d, rdy_q, rdy_d, v2_q, v2_d;
  logic [31:0] addr_q, addr_d, cap_q, cap_d;
  logic [7:0]  csd_q [16];
  logic        csd_we;
  logic        inv_q, outv_q, res_v, take_in;
  in_word_t    in_q;
  out_word_t   res, out_q;
  logic [32:0] capacity;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = outv_q & out_stall_i;
  assign take_in     = in_valid_i & ~in_stall_o;
  assign out_valid_o = outv_q;
  assign out_word_o  = out_q;

  // CSD capacity decode
  logic [21:0] c2size;
  logic [11:0] c1size;
  logic [3:0]  msh, rbl;
  logic [5:0]  shamt;
  always_comb begin
    c2size = {csd_q[7][5:0], csd_q[8], csd_q[9]};
    c1size = {csd_q[6][1:0], csd_q[7], csd_q[8][7:6]};
    msh    = 4'({csd_q[9][1:0], csd_q[10][7]}) + 4'd2;
    rbl    = csd_q[5][3:0];
    shamt  = 6'(msh) + 6'(rbl);
    if (csd_q[0][7:6] == 2'd1) begin
      capacity = (33'(c2size) + 33'd1) << 10;
    end else if (rbl < 4'd9) begin
      capacity = '0;
    end else begin
      capacity = 33'((45'(c1size) + 45'd1) << (shamt - 6'd9));
    end
  end

  function automatic logic is_cmd(input logic [4:0] p);
    return p == PH_CMD0 || p == PH_CMD8 || p == PH_CMD55 || p == PH_CMD41 ||
           p == PH_CMD58 || p == PH_CMD16 || p == PH_CMD17 || p == PH_CMD24 ||
           p == PH_CMD9;
  endfunction

  logic [5:0]  fcmd;
  logic [31:0] farg;
  logic [7:0]  fcrc, fbyte;
  logic [2:0]  fidx;
  logic [7:0]  r1;
  logic        r1_go;
  logic [7:0]  try_n;
  logic [9:0]  bcnt_n;
  logic [31:0] rcap_n;

  always_comb begin
    fcrc = 8'h01; farg = '0;
    unique case (phase_q)
      PH_CMD0:  begin fcmd = 6'd0; fcrc = 8'h95; end
      PH_CMD8:  begin fcmd = 6'd8; farg = 32'h1AA; fcrc = 8'h87; end
      PH_CMD55: fcmd = 6'd55;
      PH_CMD41: begin fcmd = 6'd41; farg = v2_q ? 32'h4000_0000 : 32'h0; end
      PH_CMD58: fcmd = 6'd58;
      PH_CMD16: begin fcmd = 6'd16; farg = 32'(BlockBytes); end
      PH_CMD17: begin fcmd = 6'd17; farg = addr_q; end
      PH_CMD24: begin fcmd = 6'd24; farg = addr_q; end
      default:  fcmd = 6'd9;
    endcase
    fidx = (bcnt_q == 10'd0) ? 3'd0 : 3'(bcnt_q - 10'd1);
    unique case (fidx)
      3'd0: fbyte = {2'b01, fcmd};
      3'd1: fbyte = farg[31:24];
      3'd2: fbyte = farg[23:16];
      3'd3: fbyte = farg[15:8];
      3'd4: fbyte = farg[7:0];
      default: fbyte = fcrc;
    endcase
  end

  always_comb begin
    phase_d = phase_q; bcnt_d = bcnt_q; try_d = try_q; ms_d = ms_q;
    blk_d = blk_q; rdy_d = rdy_q; v2_d = v2_q; addr_d = addr_q; cap_d = cap_q;
    csd_we = 1'b0; res_v = 1'b0; res = '0; res.cs_n = 1'b1;
    r1 = 8'hFF; r1_go = 1'b0;
    try_n = try_q; bcnt_n = bcnt_q + 10'd1;
    rcap_n = {cap_q[23:0], in_q.rx_byte};
    if (inv_q) begin
      if (in_q.op == OP_TICK) begin
        if (phase_q != PH_IDLE && ms_q != 16'hFFFF) ms_d = ms_q + 16'd1;
      end else if (in_q.op == OP_BYTE) begin
        if (phase_q != PH_IDLE) begin
          res_v = 1'b1; res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.cs_n = 1'b0;
          if (is_cmd(phase_q)) begin
            if (bcnt_q <= 10'd6) begin
              bcnt_d = 10'(fidx) + 10'd2; res.tx_byte = fbyte;
            end else if (bcnt_q == 10'd7) begin
              bcnt_d = 10'd8; try_d = '0;
            end else begin
              if (try_q != 8'hFF) try_n = try_q + 8'd1;
              try_d = try_n;
              if (!in_q.rx_byte[7]) begin r1_go = 1'b1; r1 = in_q.rx_byte; end
              else if (try_n >= tries_q) r1_go = 1'b1;
            end
            if (r1_go) begin
              unique case (phase_q)
                PH_CMD0:
                  if (r1 != 8'h01) res_v = 1'b0;
                  else begin phase_d = PH_CMD8; bcnt_d = 10'd1; try_d = '0; end
                PH_CMD8:
                  if (r1 == 8'h01) begin phase_d = PH_R7; bcnt_d = '0; cap_d = '0; end
                  else begin
                    v2_d = 1'b0; ms_d = '0; phase_d = PH_CMD55; bcnt_d = 10'd1; try_d = '0;
                  end
                PH_CMD55: begin phase_d = PH_CMD41; bcnt_d = 10'd1; try_d = '0; end
                PH_CMD41:
                  if (ms_q >= init_to_q) res_v = 1'b0;
                  else if (r1 != 8'h00) begin
                    phase_d = PH_CMD55; bcnt_d = 10'd1; try_d = '0;
                  end else begin
                    blk_d = 1'b0; bcnt_d = 10'd1; try_d = '0;
                    if (v2_q) phase_d = PH_CMD58;
                    else phase_d = PH_CMD16;
                  end
                PH_CMD58:
                  if (r1 != 8'h00) res_v = 1'b0;
                  else begin phase_d = PH_OCR; bcnt_d = '0; cap_d = '0; end
                PH_CMD16:
                  if (r1 != 8'h00) res_v = 1'b0;
                  else begin phase_d = PH_INIT_TAIL; res.cs_n = 1'b1; end
                PH_CMD17:
                  if (r1 != 8'h00) res_v = 1'b0;
                  else begin phase_d = PH_RTOKEN; ms_d = '0; end
                PH_CMD24:
                  if (r1 != 8'h00) res_v = 1'b0;
                  else phase_d = PH_WGAP;
                default:
                  if (r1 != 8'h00) res_v = 1'b0;
                  else begin phase_d = PH_CTOKEN; ms_d = '0; end
              endcase
              if (!res_v) begin
                res_v = 1'b1; res = '0; res.cs_n = 1'b1; res.done_res = 1'b1;
                phase_d = PH_IDLE;
                unique case (phase_q)
                  PH_CMD0:  res.status = ST_IDLE_FAIL;
                  PH_CMD41: res.status = ST_INIT_TO;
                  PH_CMD58: res.status = ST_OCR_FAIL;
                  PH_CMD16: res.status = ST_BLKLEN;
                  PH_CMD9:  res.status = ST_CAP_FAIL;
                  default:  res.status = ST_REJECT;
                endcase
              end
            end
          end else begin
            unique case (phase_q)
              PH_WAKE:
                if (bcnt_q < 10'(wake_q)) begin bcnt_d = bcnt_n; res.cs_n = 1'b1; end
                else begin phase_d = PH_CMD0; bcnt_d = 10'd1; try_d = '0; end
              PH_R7, PH_OCR: begin
                cap_d = rcap_n; bcnt_d = bcnt_n;
                if (bcnt_n >= 10'd4) begin
                  if (phase_q == PH_R7) begin
                    if (rcap_n[15:8] != 8'h01 || rcap_n[7:0] != 8'hAA) begin
                      res = '0; res.cs_n = 1'b1; res.done_res = 1'b1;
                      res.status = ST_IF_COND; phase_d = PH_IDLE;
                    end else begin
                      v2_d = 1'b1; ms_d = '0; phase_d = PH_CMD55; bcnt_d = 10'd1; try_d = '0;
                    end
                  end else begin
                    blk_d = rcap_n[30];
                    if (!rcap_n[30]) begin phase_d = PH_CMD16; bcnt_d = 10'd1; try_d = '0; end
                    else begin phase_d = PH_INIT_TAIL; res.cs_n = 1'b1; end
                  end
                end
              end
              PH_INIT_TAIL, PH_TAIL, PH_CAP_TAIL: begin
                if (phase_q == PH_INIT_TAIL) rdy_d = 1'b1;
                res = '0; res.cs_n = 1'b1; res.done_res = 1'b1; res.status = ST_OK;
                if (phase_q == PH_CAP_TAIL) res.capacity_blocks = capacity;
                phase_d = PH_IDLE;
              end
              PH_RTOKEN, PH_CTOKEN:
                if (in_q.rx_byte == 8'hFE) begin
                  phase_d = (phase_q == PH_RTOKEN) ? PH_RDATA : PH_CSD; bcnt_d = '0;
                end else if (ms_q >= token_to_q) begin
                  res = '0; res.cs_n = 1'b1; res.done_res = 1'b1; phase_d = PH_IDLE;
                  res.status = (phase_q == PH_RTOKEN) ? ST_TOKEN_TO : ST_CAP_FAIL;
                end
              PH_RDATA: begin
                bcnt_d = bcnt_n;
                if (bcnt_n >= BLOCK_CNT) begin phase_d = PH_RCRC; bcnt_d = '0; end
                res.rd_valid = 1'b1; res.rd_byte = in_q.rx_byte;
              end
              PH_CSD: begin
                csd_we = 1'b1; bcnt_d = bcnt_n;
                if (bcnt_n >= 10'd16) begin phase_d = PH_CCRC; bcnt_d = '0; end
              end
              PH_RCRC, PH_CCRC: begin
                bcnt_d = bcnt_n;
                if (bcnt_n >= 10'd2) begin
                  phase_d = (phase_q == PH_RCRC) ? PH_TAIL : PH_CAP_TAIL; res.cs_n = 1'b1;
                end
              end
              PH_WGAP: begin
                phase_d = PH_WTOKEN; res.tx_byte = 8'hFE; res.need_wr_byte = 1'b1;
              end
              PH_WTOKEN, PH_WDATA: begin
                if (phase_q == PH_WTOKEN || bcnt_q < BLOCK_CNT) begin
                  phase_d = PH_WDATA;
                  bcnt_d = (phase_q == PH_WTOKEN) ? 10'd1 : bcnt_n;
                  res.tx_byte = in_q.wr_byte;
                  res.need_wr_byte = (phase_q == PH_WTOKEN) || (bcnt_n < BLOCK_CNT);
                end else begin
                  phase_d = PH_WCRC; bcnt_d = '0;
                end
              end
              PH_WCRC: begin
                bcnt_d = bcnt_n;
                if (bcnt_n >= 10'd2) phase_d = PH_WRESP;
              end
              PH_WRESP:
                if (in_q.rx_byte[4:0] != 5'h05) begin
                  res = '0; res.cs_n = 1'b1; res.done_res = 1'b1;
                  res.status = ST_DATA_REJ; phase_d = PH_IDLE;
                end else begin phase_d = PH_WBUSY; ms_d = '0; end
              PH_WBUSY:
                if (in_q.rx_byte == 8'hFF) begin phase_d = PH_TAIL; res.cs_n = 1'b1; end
                else if (ms_q >= busy_to_q) begin
                  res = '0; res.cs_n = 1'b1; res.done_res = 1'b1;
                  res.status = ST_BUSY_TO; phase_d = PH_IDLE;
                end
              default: res_v = 1'b0;
            endcase
          end
        end
      end else if (in_q.op <= OP_CAP && phase_q == PH_IDLE) begin
        res_v = 1'b1;
        if (in_q.op == OP_INIT) begin
          rdy_d = 1'b0; v2_d = 1'b0; phase_d = PH_WAKE; bcnt_d = 10'd1;
          res.tx_valid = 1'b1; res.tx_byte = 8'hFF;
        end else if (!rdy_q) begin
          res.done_res = 1'b1; res.status = ST_NOT_READY;
        end else begin
          res.tx_valid = 1'b1; res.tx_byte = 8'hFF; res.cs_n = 1'b0;
          bcnt_d = 10'd1; try_d = '0;
          if (in_q.op == OP_CAP) phase_d = PH_CMD9;
          else begin
            addr_d = blk_q ? in_q.lba : {in_q.lba[22:0], 9'd0};
            phase_d = (in_q.op == OP_READ) ? PH_CMD17 : PH_CMD24;
          end
        end
      end
    end
    res.is_sdhc = blk_d;
    res.ready_res = rdy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_to_q <= 16'd1000; token_to_q <= 16'd200; busy_to_q <= 16'd500;
      tries_q <= 8'd10; wake_q <= 8'd10;
      phase_q <= PH_IDLE; bcnt_q <= '0; try_q <= '0; ms_q <= '0;
      blk_q <= 1'b0; rdy_q <= 1'b0; v2_q <= 1'b0; cap_q <= '0;
      inv_q <= 1'b0; outv_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_INIT_TO:  init_to_q  <= cfg_data_i;
          CFG_TOKEN_TO: token_to_q <= cfg_data_i;
          CFG_BUSY_TO:  busy_to_q  <= cfg_data_i;
          CFG_TRIES:    tries_q    <= cfg_data_i[7:0];
          CFG_WAKE:     wake_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (!in_stall_o) begin
        phase_q <= phase_d; bcnt_q <= bcnt_d; try_q <= try_d; ms_q <= ms_d;
        blk_q <= blk_d; rdy_q <= rdy_d; v2_q <= v2_d; cap_q <= cap_d;
        inv_q <= take_in;
        outv_q <= res_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) in_q <= in_word_i;
    if (!in_stall_o && res_v) out_q <= res;
    if (!in_stall_o) addr_q <= addr_d;
    if (csd_we && !in_stall_o) csd_q[bcnt_q[3:0]] <= in_q.rx_byte;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.done_res |-> !out_word_o.tx_valid && out_word_o.cs_n)
    else $error("done word with exchange");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(inv_q))
    else $error("input register moved while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> !(res_v && res.rd_valid))
    else $error("read byte while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ms_q == 16'hFFFF |=> ms_q == 16'hFFFF || ms_q == 16'd0)
    else $error("elapsed counter wrapped");
endmodule
